### rtl/named_counting_semaphore_table_defines.svh
// Assertion macros for the named counting semaphore table.
// Used by the RTL file that carries concurrent checks; expects clk and arst_n in scope.
`ifndef NAMED_COUNTING_SEMAPHORE_TABLE_DEFINES_SVH
`define NAMED_COUNTING_SEMAPHORE_TABLE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// condition holds whenever the antecedent holds
`define NCT_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
	else $error(msg);
// condition holds in the cycle after the antecedent
`define NCT_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error(msg);
`else
`define NCT_ASSERT_IMP(lbl, ante, cons, msg)
`define NCT_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

### rtl/nct_pkg.sv
// Package for the named counting semaphore table: sizes, codes, types, name mask.
// No dependencies; used by every RTL file of the block but nct_ram, and by the testbench.
package nct_pkg;

	localparam int SLOTS      = 32;
	localparam int NAME_BYTES = 8;
	localparam int IDX_W      = $clog2(SLOTS);
	localparam int CNT_W      = $clog2(SLOTS + 1);
	localparam int NAME_W     = 64;
	localparam int COUNT_W    = 32;
	localparam int USERS_W    = 16;
	localparam int SLOT_OUT_W = 5;

	localparam logic [1:0] MODE_OPEN  = 2'd0;
	localparam logic [1:0] MODE_P     = 2'd1;
	localparam logic [1:0] MODE_V     = 2'd2;
	localparam logic [1:0] MODE_CLOSE = 2'd3;

	localparam logic [1:0] STAT_OK      = 2'd0;
	localparam logic [1:0] STAT_INVALID = 2'd1;
	localparam logic [1:0] STAT_NOSPACE = 2'd2;

	localparam logic [COUNT_W-1:0] COUNT_MIN = 32'h8000_0000;
	localparam logic [COUNT_W-1:0] COUNT_MAX = 32'h7FFF_FFFF;
	localparam logic [USERS_W-1:0] USERS_MAX = 16'hFFFF;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RMW,
		S_SCAN,
		S_OPEN_WR,
		S_REPLY
	} fsm_t;

	typedef struct packed {
		logic [NAME_W-1:0]  name;
		logic [COUNT_W-1:0] count;
		logic [USERS_W-1:0] users;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic [1:0]            status;
		logic [SLOT_OUT_W-1:0] slot_id;
		logic                  must_wait;
		logic                  wake_one;
	} res_t;

	// keep bytes below len, zero the rest
	function automatic logic [NAME_W-1:0] name_mask(input logic [3:0] len);
		logic [NAME_W-1:0] m;
		m = '0;
		for (int b = 0; b < NAME_W / 8; b++) begin
			m[b*8 +: 8] = (4'(b) < len) ? 8'hFF : 8'h00;
		end
		return m;
	endfunction

endpackage

### rtl/named_counting_semaphore_table.sv
// Named counting semaphore table. P, V and close go through a read-modify-write step, bad
// slot or bad open arguments go straight to the reply, open ends at a match or after a write step.
// A new request is taken only once the reply word has been handed to the output register.
// P, V and close are a read, modify and write of one slot RAM entry; open runs the name
// scan that reads one slot per cycle through the single read port of the slot RAM.
// Reset: live bits clear at once, slot RAM contents stay undefined; no clearing pass.
`include "named_counting_semaphore_table_defines.svh"
module named_counting_semaphore_table (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [7:0]  sem_id,
	input  logic [63:0] name_text,
	input  logic [3:0]  name_length,
	input  logic signed [31:0] initial_value,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [4:0]  slot_id,
	output logic        must_wait,
	output logic        wake_one
);

	localparam int IDX_W      = nct_pkg::IDX_W;
	localparam int CNT_W      = nct_pkg::CNT_W;
	localparam int SLOT_OUT_W = nct_pkg::SLOT_OUT_W;

	// sequencer state
	nct_pkg::fsm_t state_q, state_d;

	// one live bit per slot; a slot that is not live is never compared, and only open writes it
	logic [nct_pkg::SLOTS-1:0] live_q;

	// captured request word
	logic [1:0]                   mode_q;
	logic [IDX_W-1:0]             id_q;
	logic [nct_pkg::NAME_W-1:0]   name_q;
	logic [nct_pkg::COUNT_W-1:0]  init_q;

	// name scan: cnt_q issues reads, the _s1 stage compares the data that comes back
	logic [CNT_W-1:0] cnt_q;
	logic             chk_vld_s1;
	logic [IDX_W-1:0] chk_idx_s1;
	logic             chk_live_s1;
	logic             free_found_q;
	logic [IDX_W-1:0] free_idx_q;

	// result word toward the output register
	nct_pkg::res_t res_q, res_d;
	logic          res_load;
	logic          res_valid, res_ready;
	nct_pkg::res_t out_res;

	// slot RAM port
	logic             ram_we, ram_re;
	logic [IDX_W-1:0] ram_waddr, ram_raddr;
	nct_pkg::entry_t  ram_wdata, ram_rdata;

	logic             in_acc;
	logic             open_bad, id_bad;
	logic [IDX_W-1:0] sem_idx;
	logic             scan_issue, match, scan_last;
	logic [IDX_W-1:0] scan_idx;

	// read-modify-write results
	logic [nct_pkg::COUNT_W-1:0] p_cnt, v_cnt;
	logic [nct_pkg::USERS_W-1:0] users_inc, users_dec;

	// ------------------------------------------------------------------
	// Request decode
	// ------------------------------------------------------------------
	assign in_acc   = in_valid && in_ready;
	assign sem_idx  = sem_id[IDX_W-1:0];
	assign open_bad = (name_length == 4'd0) ||
		(name_length > 4'(nct_pkg::NAME_BYTES)) || initial_value[31];
	// out-of-range ids short-circuit before the live bit matters
	assign id_bad   = ({1'b0, sem_id} >= 9'(nct_pkg::SLOTS)) || !live_q[sem_idx];

	// ------------------------------------------------------------------
	// Scan datapath
	// ------------------------------------------------------------------
	assign scan_issue = (state_q == nct_pkg::S_SCAN) && (cnt_q < CNT_W'(nct_pkg::SLOTS));
	assign scan_idx   = cnt_q[IDX_W-1:0];
	assign match      = chk_vld_s1 && chk_live_s1 && (ram_rdata.name == name_q);
	assign scan_last  = chk_vld_s1 && (chk_idx_s1 == IDX_W'(nct_pkg::SLOTS - 1));

	// ------------------------------------------------------------------
	// Count and user arithmetic, both saturating
	// ------------------------------------------------------------------
	always_comb begin
		p_cnt = (ram_rdata.count == nct_pkg::COUNT_MIN) ? ram_rdata.count
			: ram_rdata.count - 32'd1;
		v_cnt = (ram_rdata.count == nct_pkg::COUNT_MAX) ? ram_rdata.count
			: ram_rdata.count + 32'd1;
		users_inc = (ram_rdata.users == nct_pkg::USERS_MAX) ? ram_rdata.users
			: ram_rdata.users + 16'd1;
		users_dec = (ram_rdata.users == '0) ? ram_rdata.users
			: ram_rdata.users - 16'd1;
	end

	// ------------------------------------------------------------------
	// Next state
	// ------------------------------------------------------------------
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			nct_pkg::S_IDLE: begin
				if (in_valid) begin
					if (mode == nct_pkg::MODE_OPEN) begin
						state_d = open_bad ? nct_pkg::S_REPLY : nct_pkg::S_SCAN;
					end else begin
						state_d = id_bad ? nct_pkg::S_REPLY : nct_pkg::S_RMW;
					end
				end
			end
			nct_pkg::S_RMW: begin
				state_d = nct_pkg::S_REPLY;
			end
			nct_pkg::S_SCAN: begin
				if (match) begin
					state_d = nct_pkg::S_REPLY;
				end else if (scan_last) begin
					state_d = nct_pkg::S_OPEN_WR;
				end
			end
			nct_pkg::S_OPEN_WR: begin
				state_d = nct_pkg::S_REPLY;
			end
			nct_pkg::S_REPLY: begin
				if (res_ready) begin
					state_d = nct_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = nct_pkg::S_IDLE;
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Outputs of the sequencer: RAM port and result word
	// ------------------------------------------------------------------
	always_comb begin
		in_ready  = 1'b0;
		res_valid = 1'b0;
		ram_re    = 1'b0;
		ram_raddr = scan_idx;
		ram_we    = 1'b0;
		ram_waddr = id_q;
		ram_wdata = ram_rdata;
		res_load  = 1'b0;
		res_d     = '{status: nct_pkg::STAT_OK, slot_id: '0, must_wait: 1'b0, wake_one: 1'b0};
		unique case (state_q)
			nct_pkg::S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (mode == nct_pkg::MODE_OPEN) begin
						res_load     = open_bad;
						res_d.status = nct_pkg::STAT_INVALID;
					end else if (id_bad) begin
						res_load     = 1'b1;
						res_d.status = nct_pkg::STAT_INVALID;
					end else begin
						ram_re    = 1'b1;
						ram_raddr = sem_idx;
					end
				end
			end
			nct_pkg::S_RMW: begin
				ram_we   = 1'b1;
				res_load = 1'b1;
				case (mode_q)
					nct_pkg::MODE_P: begin
						ram_wdata.count = p_cnt;
						res_d.must_wait = p_cnt[31];
					end
					nct_pkg::MODE_V: begin
						ram_wdata.count = v_cnt;
						res_d.wake_one  = (v_cnt == '0) || v_cnt[31];
					end
					default: begin
						ram_wdata.users = users_dec;
					end
				endcase
			end
			nct_pkg::S_SCAN: begin
				ram_re = scan_issue;
				if (match) begin
					// name already open: one more user on the lowest matching slot
					ram_we          = 1'b1;
					ram_waddr       = chk_idx_s1;
					ram_wdata.users = users_inc;
					res_load        = 1'b1;
					res_d.slot_id   = SLOT_OUT_W'(chk_idx_s1);
				end
			end
			nct_pkg::S_OPEN_WR: begin
				res_load  = 1'b1;
				ram_waddr = free_idx_q;
				ram_wdata = '{name: name_q, count: init_q, users: 16'd1};
				if (free_found_q) begin
					ram_we        = 1'b1;
					res_d.slot_id = SLOT_OUT_W'(free_idx_q);
				end else begin
					res_d.status  = nct_pkg::STAT_NOSPACE;
				end
			end
			nct_pkg::S_REPLY: begin
				res_valid = 1'b1;
			end
			default: begin
				res_valid = 1'b0;
			end
		endcase
	end

	// ------------------------------------------------------------------
	// Control registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= nct_pkg::S_IDLE;
			live_q       <= '0;
			cnt_q        <= '0;
			chk_vld_s1   <= 1'b0;
			free_found_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			chk_vld_s1 <= scan_issue && !match;
			if (in_acc) begin
				cnt_q        <= '0;
				free_found_q <= 1'b0;
			end else if (scan_issue) begin
				cnt_q <= cnt_q + CNT_W'(1);
				// lowest free slot, noted as the scan passes it
				if (!free_found_q && !live_q[scan_idx]) begin
					free_found_q <= 1'b1;
				end
			end
			if (state_q == nct_pkg::S_RMW && mode_q == nct_pkg::MODE_CLOSE &&
				users_dec == '0) begin
				live_q[id_q] <= 1'b0;
			end
			if (state_q == nct_pkg::S_OPEN_WR && free_found_q) begin
				live_q[free_idx_q] <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Payload registers
	// ------------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (in_acc) begin
			mode_q <= mode;
			id_q   <= sem_idx;
			name_q <= name_text & nct_pkg::name_mask(name_length);
			init_q <= initial_value;
		end
		if (scan_issue) begin
			chk_idx_s1  <= scan_idx;
			chk_live_s1 <= live_q[scan_idx];
			if (!free_found_q && !live_q[scan_idx]) begin
				free_idx_q <= scan_idx;
			end
		end
		if (res_load) begin
			res_q <= res_d;
		end
	end

	// ------------------------------------------------------------------
	// Slot RAM: name, count and users of every slot in one word
	// ------------------------------------------------------------------
	nct_ram #(
		.WIDTH(nct_pkg::ENTRY_W),
		.DEPTH(nct_pkg::SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// ------------------------------------------------------------------
	// Output register
	// ------------------------------------------------------------------
	nct_outq u_outq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (res_valid),
		.in_ready (res_ready),
		.in_res   (res_q),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_res  (out_res)
	);

	assign status    = out_res.status;
	assign slot_id   = out_res.slot_id;
	assign must_wait = out_res.must_wait;
	assign wake_one  = out_res.wake_one;

	// ------------------------------------------------------------------
	// Checks
	// ------------------------------------------------------------------
	`NCT_ASSERT_IMP(a_chk_only_in_scan, chk_vld_s1, state_q == nct_pkg::S_SCAN,
		"scan compare stage active outside the scan")
	`NCT_ASSERT_IMP(a_no_rw_collide, ram_we && ram_re, ram_waddr != ram_raddr,
		"slot RAM read and write hit the same entry")
	`NCT_ASSERT_IMP(a_free_is_free, state_q == nct_pkg::S_SCAN && free_found_q,
		!live_q[free_idx_q], "noted free slot is live")
	`NCT_ASSERT_NXT(a_live_hold,
		state_q == nct_pkg::S_IDLE || state_q == nct_pkg::S_SCAN ||
		state_q == nct_pkg::S_REPLY,
		$stable(live_q), "live bits changed outside a write step")

endmodule

### rtl/nct_ram.sv
// Generic single-port-write, single-port-read synchronous RAM, registered read data.
// No package dependency.
module nct_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### rtl/nct_outq.sv
// Output register for result words; out_ready still reaches in_ready combinationally.
// Depends on nct_pkg (res_t).
module nct_outq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  nct_pkg::res_t in_res,
	output logic          out_valid,
	input  logic          out_ready,
	output nct_pkg::res_t out_res
);

	logic          valid_q;
	nct_pkg::res_t res_q;

	assign in_ready  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_res   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (in_ready) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			res_q <= in_res;
		end
	end

endmodule

### tb/sv/semaphore_table_checker.sv
// Checker for the named counting semaphore table: watches both channels, keeps its own
// copy of the slot table, and compares each reply word with the one the table implies.
// Depends on nct_pkg for sizes, mode and status codes and the reply word type.
module semaphore_table_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic                        in_ready,
	input  logic [1:0]                  mode,
	input  logic [7:0]                  sem_id,
	input  logic [nct_pkg::NAME_W-1:0]  name_text,
	input  logic [3:0]                  name_length,
	input  logic [nct_pkg::COUNT_W-1:0] initial_value,
	input  logic                        out_valid,
	input  logic                        out_ready,
	input  logic [1:0]                  status,
	input  logic [4:0]                  slot_id,
	input  logic                        must_wait,
	input  logic                        wake_one,
	output int                          mismatch_count,
	output int                          owed_replies
);
	timeunit 1ns;
	timeprecision 1ps;

	logic                        sem_live  [nct_pkg::SLOTS];
	logic [nct_pkg::NAME_W-1:0]  sem_name  [nct_pkg::SLOTS];
	logic [nct_pkg::COUNT_W-1:0] sem_count [nct_pkg::SLOTS];
	logic [nct_pkg::USERS_W-1:0] sem_users [nct_pkg::SLOTS];

	nct_pkg::res_t replies_due[$];
	int            bad;
	int            reply_no;

	// applies one request to the table copy and returns the reply it earns
	function automatic nct_pkg::res_t semaphore_op_reply(input logic [1:0] op,
			input logic [7:0] id, input logic [nct_pkg::NAME_W-1:0] text,
			input logic [3:0] len, input logic [nct_pkg::COUNT_W-1:0] init);
		nct_pkg::res_t               r;
		logic [nct_pkg::NAME_W-1:0]  key;
		logic [nct_pkg::COUNT_W-1:0] c;
		int                          hit;
		int                          b;
		r = '0;
		if (op == nct_pkg::MODE_OPEN) begin
			if (len == 0 || len > nct_pkg::NAME_BYTES || init[nct_pkg::COUNT_W-1]) begin
				r.status = nct_pkg::STAT_INVALID;
			end else begin
				key = '0;
				for (b = 0; b < nct_pkg::NAME_W / 8; b++)
					if (b < len) key[b*8 +: 8] = text[b*8 +: 8];
				hit = -1;
				for (b = 0; b < nct_pkg::SLOTS; b++)
					if (hit < 0 && sem_live[b] && sem_name[b] == key) hit = b;
				if (hit >= 0) begin
					if (sem_users[hit] != nct_pkg::USERS_MAX)
						sem_users[hit] = sem_users[hit] + 1'b1;
				end else begin
					for (b = 0; b < nct_pkg::SLOTS; b++)
						if (hit < 0 && !sem_live[b]) hit = b;
					if (hit >= 0) begin
						sem_live[hit]  = 1'b1;
						sem_name[hit]  = key;
						sem_count[hit] = init;
						sem_users[hit] = 1;
					end
				end
				if (hit >= 0) begin
					r.status  = nct_pkg::STAT_OK;
					r.slot_id = hit[nct_pkg::SLOT_OUT_W-1:0];
				end else begin
					r.status = nct_pkg::STAT_NOSPACE;
				end
			end
		end else if (id >= nct_pkg::SLOTS || !sem_live[id]) begin
			r.status = nct_pkg::STAT_INVALID;
		end else begin
			r.status = nct_pkg::STAT_OK;
			c = sem_count[id];
			case (op)
				nct_pkg::MODE_P: begin
					if (c != nct_pkg::COUNT_MIN) c = c - 1'b1;
					sem_count[id] = c;
					r.must_wait = c[nct_pkg::COUNT_W-1];
				end
				nct_pkg::MODE_V: begin
					if (c != nct_pkg::COUNT_MAX) c = c + 1'b1;
					sem_count[id] = c;
					r.wake_one = (c == '0) || c[nct_pkg::COUNT_W-1];
				end
				nct_pkg::MODE_CLOSE: begin
					if (sem_users[id] != '0) sem_users[id] = sem_users[id] - 1'b1;
					if (sem_users[id] == '0) sem_live[id] = 1'b0;
				end
				default: ;
			endcase
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		nct_pkg::res_t want;
		int            s;
		if (!arst_n) begin
			for (s = 0; s < nct_pkg::SLOTS; s++) sem_live[s] = 1'b0;
			replies_due.delete();
			bad = 0;
			reply_no = 0;
			mismatch_count <= 0;
			owed_replies <= 0;
		end else begin
			if (in_valid && in_ready)
				replies_due.push_back(semaphore_op_reply(mode, sem_id, name_text,
					name_length, initial_value));
			if (out_valid && out_ready) begin
				if (replies_due.size() == 0) begin
					bad++;
					if (bad <= 10)
						$display("reply %0d: unexpected word status %0d slot %0d wait %0b wake %0b",
							reply_no, status, slot_id, must_wait, wake_one);
				end else begin
					want = replies_due.pop_front();
					if (want.status !== status || want.slot_id !== slot_id ||
							want.must_wait !== must_wait || want.wake_one !== wake_one) begin
						bad++;
						if (bad <= 10)
							$display("reply %0d: exp status %0d slot %0d wait %0b wake %0b, got %0d %0d %0b %0b",
								reply_no, want.status, want.slot_id, want.must_wait,
								want.wake_one, status, slot_id, must_wait, wake_one);
					end
				end
				reply_no++;
			end
			mismatch_count <= bad;
			owed_replies <= replies_due.size();
		end
	end

endmodule

### tb/sv/tb_named_counting_semaphore_table.sv
// Top of the semaphore table testbench: clock, reset, request stimulus, reply stalls, verdict.
// Depends on nct_pkg, the named_counting_semaphore_table RTL and semaphore_table_checker.
module tb_named_counting_semaphore_table;
	timeunit 1ns;
	timeprecision 1ps;

	// a full open plus both idle draws is far below this; the long
	// reply hold-off is the worst quiet stretch a correct run can show
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 300;
	localparam int POOL           = 16;
	localparam int RANDOM_WORDS   = 960;

	logic         clk = 1'b0;
	logic         arst_n = 1'b0;
	logic         in_valid = 1'b0;
	logic         in_ready;
	logic [1:0]   mode = nct_pkg::MODE_OPEN;
	logic [7:0]   sem_id = '0;
	logic [63:0]  name_text = '0;
	logic [3:0]   name_length = '0;
	logic [31:0]  initial_value = '0;
	logic         out_valid;
	logic         out_ready = 1'b0;
	logic [1:0]   status;
	logic [4:0]   slot_id;
	logic         must_wait;
	logic         wake_one;

	int mismatch_count;
	int owed_replies;
	int stall_cycles = 0;

	// shared knobs: no_gaps turns off idling on both sides, hold_req asks the
	// reply side for one long hold-off (it clears the flag when done)
	bit no_gaps = 1'b0;
	bit hold_req = 1'b0;

	logic [63:0] pool_text [POOL];
	logic [3:0]  pool_len  [POOL];

	always #1ns clk = ~clk;

	named_counting_semaphore_table dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.mode         (mode),
		.sem_id       (sem_id),
		.name_text    (name_text),
		.name_length  (name_length),
		.initial_value(initial_value),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.slot_id      (slot_id),
		.must_wait    (must_wait),
		.wake_one     (wake_one)
	);

	semaphore_table_checker audit (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.mode          (mode),
		.sem_id        (sem_id),
		.name_text     (name_text),
		.name_length   (name_length),
		.initial_value (initial_value),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.status        (status),
		.slot_id       (slot_id),
		.must_wait     (must_wait),
		.wake_one      (wake_one),
		.mismatch_count(mismatch_count),
		.owed_replies  (owed_replies)
	);

	// Offer one request word and return at the edge that takes it. Valid is left
	// high on return: the next call in the same step either swaps the payload
	// (no gap) or drops valid once, so valid never toggles twice in one step.
	task automatic send_request(input logic [1:0] m, input logic [7:0] id,
			input logic [63:0] text, input logic [3:0] len, input logic [31:0] init);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 9);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		mode          <= m;
		sem_id        <= id;
		name_text     <= text;
		name_length   <= len;
		initial_value <= init;
		do @(posedge clk); while (!in_ready);
	endtask

	task automatic open_sem(input logic [63:0] text, input logic [3:0] len,
			input logic [31:0] init);
		send_request(nct_pkg::MODE_OPEN, 8'($urandom_range(0, 255)), text, len, init);
	endtask

	// P, V or close; the open-only fields carry junk the block must ignore
	task automatic poke_sem(input logic [1:0] m, input logic [7:0] id);
		send_request(m, id, {$urandom, $urandom}, 4'($urandom_range(0, 15)), $urandom);
	endtask

	// drop valid and hold the request side until every reply is back; the first
	// edge lets the outstanding count catch up with the last accepted word
	task automatic drain_replies();
		in_valid <= 1'b0;
		@(posedge clk);
		while (owed_replies != 0) @(posedge clk);
	endtask

	// reply side: fresh idle draw per word, one long hold-off on request
	initial begin
		int gap;
		@(posedge arst_n);
		forever begin
			gap = no_gaps ? 0 : $urandom_range(0, 9);
			if (hold_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (gap != 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// watchdog: any accepted word on either channel restarts the count
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= WATCHDOG_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		int          n;
		int          k;
		int          pick;
		logic [7:0]  slot;
		logic [31:0] init;
		logic [63:0] junk;

		for (k = 0; k < POOL; k++) begin
			pool_text[k] = {$urandom, $urandom};
			pool_len[k]  = 4'($urandom_range(1, nct_pkg::NAME_BYTES));
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed ---
		// bad open arguments: zero length, too long, negative start count
		open_sem(64'h0, 4'd0, 32'd0);
		open_sem(64'h41, 4'(nct_pkg::NAME_BYTES + 1), 32'd0);
		open_sem(64'h41, 4'hF, 32'd0);
		open_sem(64'h41, 4'd1, 32'hFFFF_FFFF);
		open_sem(64'h41, 4'd1, nct_pkg::COUNT_MIN);
		// bad slot: free, far out of range, just past the table
		poke_sem(nct_pkg::MODE_P, 8'd0);
		poke_sem(nct_pkg::MODE_V, 8'hFF);
		poke_sem(nct_pkg::MODE_CLOSE, 8'(nct_pkg::SLOTS));
		// bytes past the length are ignored, so both opens land on slot 0
		open_sem(64'hDEAD_BEEF_CAFE_0041, 4'd1, 32'd0);
		open_sem(64'h1234_5678_9ABC_DE41, 4'd1, 32'd9);
		poke_sem(nct_pkg::MODE_P, 8'd0);	// count -1: must wait
		poke_sem(nct_pkg::MODE_V, 8'd0);	// back to 0: wake one
		poke_sem(nct_pkg::MODE_V, 8'd0);	// positive: nobody to wake
		// full-width name at the top count, V saturates
		open_sem(64'hFFFF_FFFF_FFFF_FFFF, 4'd8, nct_pkg::COUNT_MAX);
		poke_sem(nct_pkg::MODE_V, 8'd1);
		poke_sem(nct_pkg::MODE_P, 8'd1);
		// all-zero names of different length compare equal after masking
		open_sem(64'hFFFF_FF00_0000_0000, 4'd3, 32'd5);
		open_sem(64'h0000_AB00_0000_0000, 4'd5, 32'd7);
		// close down to free, then the freed slot is rejected
		poke_sem(nct_pkg::MODE_CLOSE, 8'd0);
		poke_sem(nct_pkg::MODE_CLOSE, 8'd0);
		poke_sem(nct_pkg::MODE_P, 8'd0);
		poke_sem(nct_pkg::MODE_CLOSE, 8'd1);
		poke_sem(nct_pkg::MODE_CLOSE, 8'd2);
		poke_sem(nct_pkg::MODE_CLOSE, 8'd2);
		open_sem(64'h41, 4'd1, 32'd0);

		// --- random traffic ---
		// mostly well-formed: opens from a small name pool so names repeat,
		// P/V/close aimed at the low slots where live entries sit; the rest
		// is opens with random fields and requests of any mode to any slot id
		for (n = 0; n < RANDOM_WORDS; n++) begin
			if (n % 100 == 0) no_gaps = ($urandom_range(0, 3) == 0);
			// long reply stall while requests keep coming
			if (n == 300) hold_req = 1'b1;
			// burst of fresh names: fills the table and runs into no-space
			if (n == 450)
				for (k = 0; k < nct_pkg::SLOTS + 4; k++)
					open_sem({$urandom, $urandom}, 4'd8, $urandom_range(0, 5));
			// request side goes quiet until every reply is in
			if (n == 650) drain_replies();

			pick = $urandom_range(0, 99);
			k    = $urandom_range(0, POOL - 1);
			slot = ($urandom_range(0, 6) != 0) ? 8'($urandom_range(0, 19))
				: 8'($urandom_range(0, nct_pkg::SLOTS - 1));
			case ($urandom_range(0, 9))
				0, 1:    init = nct_pkg::COUNT_MAX;
				2, 3, 4: init = $urandom & 32'h7FFF_FFFF;
				default: init = $urandom_range(0, 3);
			endcase
			if (pick < 30) begin
				// same name, different junk above its length
				junk = {$urandom, $urandom};
				open_sem(pool_text[k] ^ (junk << (8 * pool_len[k])), pool_len[k], init);
			end else if (pick < 45) begin
				poke_sem(nct_pkg::MODE_P, slot);
			end else if (pick < 60) begin
				poke_sem(nct_pkg::MODE_V, slot);
			end else if (pick < 80) begin
				poke_sem(nct_pkg::MODE_CLOSE, slot);
			end else if (pick < 92) begin
				open_sem({$urandom, $urandom}, 4'($urandom_range(0, 15)), $urandom);
			end else begin
				send_request(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
					{$urandom, $urandom}, 4'($urandom_range(0, 15)), $urandom);
			end
		end

		// --- wind down ---
		no_gaps = 1'b0;
		drain_replies();
		// nothing may trickle out after the last reply
		repeat (40) @(posedge clk);
		if (mismatch_count == 0 && owed_replies == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

### files.f
+incdir+rtl
rtl/nct_pkg.sv
rtl/nct_ram.sv
rtl/nct_outq.sv
rtl/named_counting_semaphore_table.sv
tb/sv/semaphore_table_checker.sv
tb/sv/tb_named_counting_semaphore_table.sv
